[rtl/dgra_pkg.sv]
`timescale 1ns / 1ps
package dgra_pkg;

    localparam int SAMPLE_W = 32;
    localparam int DEV_W    = 31;
    localparam int LEN_W    = 11;
    localparam int GAIN_W   = 16;
    localparam int NUM_W    = 64;
    localparam int ROOT_W   = 32;

    // register indexes on the config port
    localparam logic [2:0] REG_GAIN_PLUS  = 3'd0;
    localparam logic [2:0] REG_GAIN_MINUS = 3'd1;
    localparam logic [2:0] REG_OFFSET     = 3'd2;
    localparam logic [2:0] REG_AVG_LEN    = 3'd3;
    localparam logic [2:0] REG_STD_EN     = 3'd4;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain_plus;
        logic signed [GAIN_W-1:0]   gain_minus;
        logic signed [SAMPLE_W-1:0] offset_value;
        logic [LEN_W-1:0]           average_length;
        logic                       std_enable;
    } t_cfg;

    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD,
        C_MULP,
        C_MULM,
        C_VDIF,
        C_VSAT,
        C_MSQ,
        C_FIRST,
        C_WACC,
        C_DIVM,
        C_MEAN,
        C_MM,
        C_DIVQ,
        C_VAR,
        C_DEVW,
        C_DIFF,
        C_EMAN,
        C_DM,
        C_DIVD,
        C_DEVE,
        C_OUT
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic warm;
        logic std_en;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } t_status;

endpackage

[rtl/dgra_sample_if.sv]
`timescale 1ns / 1ps
interface dgra_sample_if;
    import dgra_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] plus_sample;
    logic signed [SAMPLE_W-1:0] minus_sample;
    modport source (output valid, output plus_sample, output minus_sample, input ready);
    modport sink (input valid, input plus_sample, input minus_sample, output ready);
endinterface

[rtl/dgra_result_if.sv]
`timescale 1ns / 1ps
interface dgra_result_if;
    import dgra_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] averaged_value;
    logic [DEV_W-1:0]           deviation_value;
    modport source (output valid, output averaged_value, output deviation_value, input ready);
    modport sink (input valid, input averaged_value, input deviation_value, output ready);
endinterface

[rtl/dgra_div.sv]
`timescale 1ns / 1ps
module dgra_div
    import dgra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [LEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [LEN_W-1:0] r_den;
    logic [LEN_W:0]   r_rem;
    logic [LEN_W:0]   n_trial;
    logic             n_ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_trial = {r_rem[LEN_W-1:0], r_q[NUM_W-1]};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
            r_q    <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_trial - {1'b0, r_den}) : n_trial;
            r_q   <= {r_q[NUM_W-2:0], n_ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

[rtl/dgra_sqrt.sv]
`timescale 1ns / 1ps
module dgra_sqrt
    import dgra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_x,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_x;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+1:0] n_rem;
    logic [ROOT_W+1:0] n_trial;
    logic              n_ge;

    // two radicand bits per cycle
    always_comb begin
        n_rem   = {r_rem[ROOT_W-1:0], r_x[NUM_W-1:NUM_W-2]};
        n_trial = {r_root, 2'b01};
        n_ge    = (n_rem >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ROOT_W);
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? (n_rem - n_trial) : n_rem;
            r_root <= {r_root[ROOT_W-2:0], n_ge};
            r_x    <= {r_x[NUM_W-3:0], 2'b00};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

[rtl/dgra_ctrl.sv]
`timescale 1ns / 1ps
module dgra_ctrl
    import dgra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_MULP, S_MULM, S_VDIF, S_VSAT,
        S_F_SQ, S_F_SET,
        S_W_SQ, S_W_ACC, S_W_DIVM, S_W_WAITM, S_W_MEAN,
        S_W_MM, S_W_DIVQ, S_W_WAITQ, S_W_VAR, S_W_WAITS, S_W_DEVW,
        S_E_DIFF, S_E_DIVN, S_E_WAITN, S_E_MEAN,
        S_E_DM, S_E_DIVD, S_E_WAITD, S_E_DEVE,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = C_LOAD;
                    n_state = S_MULP;
                end
            end
            S_MULP: begin o_cmd = C_MULP; n_state = S_MULM; end
            S_MULM: begin o_cmd = C_MULM; n_state = S_VDIF; end
            S_VDIF: begin o_cmd = C_VDIF; n_state = S_VSAT; end
            S_VSAT: begin
                o_cmd = C_VSAT;
                if (i_status.count_zero) n_state = S_F_SQ;
                else if (i_status.warm)  n_state = S_W_SQ;
                else                     n_state = S_E_DIFF;
            end
            S_F_SQ:    begin o_cmd = C_MSQ;   n_state = S_F_SET; end
            S_F_SET:   begin o_cmd = C_FIRST; n_state = S_OUT; end
            S_W_SQ:    begin o_cmd = C_MSQ;   n_state = S_W_ACC; end
            S_W_ACC:   begin o_cmd = C_WACC;  n_state = S_W_DIVM; end
            S_W_DIVM:  begin o_cmd = C_DIVM;  n_state = S_W_WAITM; end
            S_W_WAITM: begin if (!i_status.div_busy) n_state = S_W_MEAN; end
            S_W_MEAN: begin
                o_cmd   = C_MEAN;
                n_state = i_status.std_en ? S_W_MM : S_OUT;
            end
            S_W_MM:    begin o_cmd = C_MM;    n_state = S_W_DIVQ; end
            S_W_DIVQ:  begin o_cmd = C_DIVQ;  n_state = S_W_WAITQ; end
            S_W_WAITQ: begin if (!i_status.div_busy) n_state = S_W_VAR; end
            S_W_VAR:   begin o_cmd = C_VAR;   n_state = S_W_WAITS; end
            S_W_WAITS: begin if (!i_status.sqrt_busy) n_state = S_W_DEVW; end
            S_W_DEVW:  begin o_cmd = C_DEVW;  n_state = S_OUT; end
            S_E_DIFF:  begin o_cmd = C_DIFF;  n_state = S_E_DIVN; end
            S_E_DIVN:  begin o_cmd = C_EMAN;  n_state = S_E_WAITN; end
            S_E_WAITN: begin if (!i_status.div_busy) n_state = S_E_MEAN; end
            S_E_MEAN: begin
                o_cmd   = C_MEAN;
                n_state = i_status.std_en ? S_E_DM : S_OUT;
            end
            S_E_DM:    begin o_cmd = C_DM;    n_state = S_E_DIVD; end
            S_E_DIVD:  begin o_cmd = C_DIVD;  n_state = S_E_WAITD; end
            S_E_WAITD: begin if (!i_status.div_busy) n_state = S_E_DEVE; end
            S_E_DEVE:  begin o_cmd = C_DEVE;  n_state = S_OUT; end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd   = C_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

[rtl/dgra_dp.sv]
`timescale 1ns / 1ps
module dgra_dp
    import dgra_pkg::*;
#(
    parameter int MAX_AVERAGE = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_clear,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_plus,
    input  logic signed [SAMPLE_W-1:0] i_minus,
    input  logic                       i_out_ready,
    output t_status                    o_status,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_avg,
    output logic [DEV_W-1:0]           o_dev
);
    localparam int SUM_W = 48;
    localparam int MUL_W = 33;
    localparam int VS_W  = 42;
    localparam int EM_W  = 44;
    localparam logic signed [VS_W-1:0] SMAX = VS_W'(2**(SAMPLE_W-1) - 1);
    localparam logic signed [VS_W-1:0] SMIN = -SMAX - VS_W'(1);

    // item and running state
    logic signed [SAMPLE_W-1:0] r_plus, r_minus, r_v, r_mean;
    logic signed [2*MUL_W-1:0]  r_pa, r_prod;
    logic signed [SUM_W-1:0]    r_sum;
    logic [NUM_W-1:0]           r_sumsq;
    logic [DEV_W-1:0]           r_dev;
    logic [LEN_W-1:0]           r_count;
    logic [SAMPLE_W:0]          r_ad;
    logic                       r_neg;
    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_o_avg;
    logic [DEV_W-1:0]           r_o_dev;

    logic [LEN_W-1:0]           len_eff, dev_k, dev_den;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [VS_W-1:0]     v_sum;
    logic signed [SAMPLE_W:0]   d_diff;
    logic signed [EM_W-1:0]     em_num;
    logic [NUM_W:0]             sq_acc;
    logic                       div_start, div_busy, sqrt_start, sqrt_busy;
    logic [NUM_W-1:0]           div_num, div_q, sqrt_x, m2;
    logic [LEN_W-1:0]           div_den;
    logic [ROOT_W-1:0]          root;

    always_comb begin
        if (i_cfg.average_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(i_cfg.average_length) > 32'(MAX_AVERAGE)) begin
            len_eff = LEN_W'(MAX_AVERAGE);
        end else begin
            len_eff = i_cfg.average_length;
        end
        dev_k   = (len_eff > LEN_W'(1)) ? (len_eff - LEN_W'(1)) : LEN_W'(19);
        dev_den = (len_eff > LEN_W'(1)) ? len_eff : LEN_W'(20);
    end

    // shared multiplier, result always registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd)
            C_MULP: begin
                mul_a = MUL_W'(r_plus);
                mul_b = MUL_W'(i_cfg.gain_plus);
            end
            C_MULM: begin
                mul_a = MUL_W'(r_minus);
                mul_b = MUL_W'(i_cfg.gain_minus);
            end
            C_MSQ: begin
                mul_a = MUL_W'(r_v);
                mul_b = MUL_W'(r_v);
            end
            C_MM: begin
                mul_a = MUL_W'(r_mean);
                mul_b = MUL_W'(r_mean);
            end
            C_DIFF: begin
                mul_a = MUL_W'(r_mean);
                mul_b = $signed({{(MUL_W-LEN_W){1'b0}}, len_eff - LEN_W'(1)});
            end
            C_DM: begin
                mul_a = $signed({{(MUL_W-DEV_W){1'b0}}, r_dev});
                mul_b = $signed({{(MUL_W-LEN_W){1'b0}}, dev_k});
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        v_sum  = VS_W'(r_pa >>> 8) + VS_W'(i_cfg.offset_value);
        d_diff = (SAMPLE_W+1)'(r_v) - (SAMPLE_W+1)'(r_mean);
        em_num = EM_W'(r_v) + EM_W'(r_prod);
        sq_acc = {1'b0, r_sumsq} + {1'b0, r_prod[NUM_W-1:0]};
        m2     = r_prod[NUM_W-1:0];
        sqrt_x = (div_q > m2) ? (div_q - m2) : '0;
    end

    // divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = r_count;
        case (i_cmd)
            C_DIVM: begin
                div_start = 1'b1;
                div_num   = NUM_W'(r_sum[SUM_W-1] ? -r_sum : r_sum);
            end
            C_DIVQ: begin
                div_start = 1'b1;
                div_num   = r_sumsq;
            end
            C_EMAN: begin
                div_start = 1'b1;
                div_num   = NUM_W'(em_num[EM_W-1] ? -em_num : em_num);
                div_den   = len_eff;
            end
            C_DIVD: begin
                div_start = 1'b1;
                div_num   = r_prod[NUM_W-1:0] + NUM_W'(r_ad);
                div_den   = dev_den;
            end
            default: ;
        endcase
    end

    assign sqrt_start = (i_cmd == C_VAR);

    dgra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    dgra_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     (sqrt_x),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= '0;
            r_sum   <= '0;
            r_mean  <= '0;
            r_sumsq <= '0;
            r_dev   <= '0;
        end else begin
            case (i_cmd)
                C_FIRST: begin
                    r_sum   <= SUM_W'(r_v);
                    r_mean  <= r_v;
                    r_sumsq <= r_prod[NUM_W-1:0];
                    r_dev   <= '0;
                    r_count <= LEN_W'(1);
                end
                C_WACC: begin
                    r_sum   <= r_sum + SUM_W'(r_v);
                    r_count <= r_count + LEN_W'(1);
                    r_sumsq <= sq_acc[NUM_W] ? '1 : sq_acc[NUM_W-1:0];
                end
                C_MEAN: r_mean <= r_neg ? -div_q[SAMPLE_W-1:0] : div_q[SAMPLE_W-1:0];
                C_DEVW: r_dev <= root[ROOT_W-1] ? '1 : root[DEV_W-1:0];
                C_DIFF: r_count <= len_eff + LEN_W'(1);
                C_DEVE: r_dev <= (|div_q[NUM_W-1:DEV_W]) ? '1 : div_q[DEV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_LOAD: begin
                r_plus  <= i_plus;
                r_minus <= i_minus;
            end
            C_MULP:  r_pa <= mul_p;
            C_VDIF:  r_pa <= r_pa - r_prod;
            C_VSAT: begin
                if (v_sum > SMAX)      r_v <= SAMPLE_W'(SMAX);
                else if (v_sum < SMIN) r_v <= SAMPLE_W'(SMIN);
                else                   r_v <= SAMPLE_W'(v_sum);
            end
            C_MULM, C_MSQ, C_MM, C_DM: r_prod <= mul_p;
            C_DIFF: begin
                r_prod <= mul_p;
                r_ad   <= d_diff[SAMPLE_W] ? (SAMPLE_W+1)'(-d_diff) : (SAMPLE_W+1)'(d_diff);
            end
            C_DIVM:  r_neg <= r_sum[SUM_W-1];
            C_EMAN:  r_neg <= em_num[EM_W-1];
            C_OUT: begin
                r_o_avg <= r_mean;
                r_o_dev <= r_dev;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd == C_OUT) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.count_zero = (r_count == '0);
        o_status.warm       = ({1'b0, r_count} + (LEN_W+1)'(1)) <= {1'b0, len_eff};
        o_status.std_en     = i_cfg.std_enable;
        o_status.div_busy   = div_busy;
        o_status.sqrt_busy  = sqrt_busy;
        o_status.out_free   = !r_o_valid || i_out_ready;
    end

    assign o_valid = r_o_valid;
    assign o_avg   = r_o_avg;
    assign o_dev   = r_o_dev;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= ({1'b0, len_eff} + (LEN_W+1)'(1)))
        else $error("sample count beyond length plus one");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("square root started while busy");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_count == '0 && r_dev == '0))
        else $error("config write did not clear state");
endmodule

[rtl/differential_gain_running_average_top.sv]
`timescale 1ns / 1ps
// a result is registered once the sequencer has stepped an item through its states:
// the first item uses no divider, exponential and warm-up modes wait on a serial
// division, and with deviation on a second division (exponential) or on a second
// division and the serial square root (warm-up); the next word is taken while a
// result waits, the sequencer stalls only when a second result is ready
// reset: synchronous active low, restores register defaults and clears the running state
module differential_gain_running_average_top
    import dgra_pkg::*;
#(
    parameter int MAX_AVERAGE = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dgra_sample_if.sink   i_sample,
    dgra_result_if.source o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    // configuration registers
    t_cfg       r_cfg;
    logic       cfg_wr;
    logic       cfg_hit;
    logic [2:0] reg_idx;
    t_cmd       cmd;
    t_status    status;
    logic       in_ready;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    // any write to a real register also clears the running state
    always_comb begin
        unique case (reg_idx)
            REG_GAIN_PLUS, REG_GAIN_MINUS, REG_OFFSET, REG_AVG_LEN, REG_STD_EN:
                cfg_hit = 1'b1;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_plus      <= 16'sd256;
            r_cfg.gain_minus     <= 16'sd256;
            r_cfg.offset_value   <= '0;
            r_cfg.average_length <= LEN_W'(1);
            r_cfg.std_enable     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GAIN_PLUS:  r_cfg.gain_plus      <= pwdata[GAIN_W-1:0];
                REG_GAIN_MINUS: r_cfg.gain_minus     <= pwdata[GAIN_W-1:0];
                REG_OFFSET:     r_cfg.offset_value   <= pwdata;
                REG_AVG_LEN:    r_cfg.average_length <= pwdata[LEN_W-1:0];
                REG_STD_EN:     r_cfg.std_enable     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_GAIN_PLUS:  prdata = 32'($unsigned(r_cfg.gain_plus));
            REG_GAIN_MINUS: prdata = 32'($unsigned(r_cfg.gain_minus));
            REG_OFFSET:     prdata = r_cfg.offset_value;
            REG_AVG_LEN:    prdata = 32'(r_cfg.average_length);
            REG_STD_EN:     prdata = 32'(r_cfg.std_enable);
            default:        prdata = '0;
        endcase
    end

    // sequencer: steps the datapath through one item at a time
    dgra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_sample.ready = in_ready;

    // arithmetic, divider, square root and output register
    dgra_dp #(
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_clear     (cfg_wr && cfg_hit),
        .i_cmd       (cmd),
        .i_plus      (i_sample.plus_sample),
        .i_minus     (i_sample.minus_sample),
        .i_out_ready (o_result.ready),
        .o_status    (status),
        .o_valid     (o_result.valid),
        .o_avg       (o_result.averaged_value),
        .o_dev       (o_result.deviation_value)
    );
endmodule
